[sv/vending_controller_with_change_core_defines.svh]
// ----------------------------------------------------------------------------
// vending_controller_with_change_core_defines
// Assertion macros shared by the vending controller RTL.
// ----------------------------------------------------------------------------
`ifndef VENDING_CONTROLLER_WITH_CHANGE_CORE_DEFINES_SVH
`define VENDING_CONTROLLER_WITH_CHANGE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define VCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/vcc_pkg.sv]
// ----------------------------------------------------------------------------
// vcc_pkg
// Shared types, codes and constants of the vending controller.
// ----------------------------------------------------------------------------
`default_nettype none

package vcc_pkg;

  localparam int unsigned MaxSlots    = 5;  // price registers in the map
  localparam int unsigned NumSlotsDef = 5;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned PriceW      = 8;
  localparam int unsigned StockW      = 8;
  localparam int unsigned CoinInW     = 8;
  localparam int unsigned CoinOutW    = 5;
  localparam int unsigned SlotW       = 3;
  localparam int unsigned ItemCntW    = 3;

  // a purchase run carries at most this many words before the done word
  localparam logic [ItemCntW-1:0] ItemCap = ItemCntW'(6);

  localparam logic [StockW-1:0] StockRst = StockW'(5);

  localparam logic [MaxSlots-1:0][PriceW-1:0] PriceRst = {
    PriceW'(35), PriceW'(27), PriceW'(22), PriceW'(32), PriceW'(25)
  };

  typedef enum logic [1:0] {
    REQ_SELECT = 2'd0,
    REQ_COIN   = 2'd1,
    REQ_STOCK  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_SELECTED    = 3'd0,
    ST_BAD_SLOT    = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_COIN_OK     = 3'd3,
    ST_COIN_REJ    = 3'd4,
    ST_CHANGE      = 3'd5,
    ST_DONE        = 3'd6,
    ST_WRONG_PHASE = 3'd7
  } status_e;

  // what a decoded request leads to
  typedef enum logic [1:0] {
    OC_NONE,        // unknown request, no word
    OC_SINGLE,      // one word, then idle
    OC_ZERO_PRICE,  // selected word, then change run
    OC_PAY          // change run straight away
  } outcome_e;

  typedef struct packed {
    logic latch_in;
    logic eval_fire;
    logic step_fire;
  } vcc_cmd_t;

  typedef struct packed {
    logic     out_free;
    outcome_e outcome;
    logic     run_end;
  } vcc_sts_t;

  // change coin for a remainder: 20, 10, 5 or 1 by divisibility
  function automatic logic [CoinOutW-1:0] change_coin(input logic [CoinOutW-1:0] c);
    logic by5;
    logic by10;
    logic by20;
    by20 = (c == 5'd20);
    by10 = (c == 5'd10) || (c == 5'd20) || (c == 5'd30);
    by5  = by10 || (c == 5'd5) || (c == 5'd15) || (c == 5'd25);
    if (by20) begin
      change_coin = 5'd20;
    end else if (by10) begin
      change_coin = 5'd10;
    end else if (by5) begin
      change_coin = 5'd5;
    end else begin
      change_coin = 5'd1;
    end
  endfunction

endpackage

`default_nettype wire

[sv/vending_controller_with_change_core.sv]
// ----------------------------------------------------------------------------
// vending_controller_with_change_core
// Five-slot vending controller: selection, coin intake, restock, change payout.
// ----------------------------------------------------------------------------
// A request word (select, coin or restock) is taken when the input is idle and
// answered with one result word, or for a completed purchase with a run of
// change words (status change, one coin each, largest coin that divides the
// remainder) closed by a done word with coin 0 and tlast high; a run holds at
// most seven words and any change beyond six words is not paid. A request is
// latched on acceptance and evaluated in the EVAL state; a plain request
// loads its one result word there and the block returns to idle. A zero-price
// select loads the selected word at evaluation and then the done word. A coin
// that completes a purchase loads nothing at evaluation; its change words
// follow in the CHANGE state, one a cycle while the output is free, then the
// done word, so the longest run is six change words and done. Every load
// waits while the output register holds an untaken word, so downstream stalls
// hold the block back. The next request is taken from the cycle after the
// last result word is loaded, while that word may still wait downstream.
// Prices are written through the cfg port (index 0..4 for slots 1..5, other
// indexes ignored); the user must do so only while the block is idle, as the
// block does not enforce it. Request type 3 produces no result. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module vending_controller_with_change_core
  import vcc_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDef  // 1..5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // price configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [PriceW-1:0]  cfg_wdata_i,
  // request words
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // slot_number[2:0], coin_value[10:3],
                                             // stock_value[18:11], zero pad
  input  logic [1:0]         s_axis_tuser,   // req_type
  // result words
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,   // coin_out[4:0], amount_left[12:5],
                                             // zero pad
  output logic [2:0]         m_axis_tuser,   // status
  output logic               m_axis_tlast    // last
);

  vcc_cmd_t            cmd;
  vcc_sts_t            sts;
  status_e             out_status;
  logic [CoinOutW-1:0] out_coin;
  logic [PriceW-1:0]   out_left;

  vcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vcc_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_i        (s_axis_tuser),
    .slot_i       (s_axis_tdata[2:0]),
    .coin_i       (s_axis_tdata[10:3]),
    .stockv_i     (s_axis_tdata[18:11]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_coin_o   (out_coin),
    .out_left_o   (out_left),
    .out_last_o   (m_axis_tlast),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {3'b000, out_left, out_coin};

endmodule

`default_nettype wire

[sv/vcc_ctrl.sv]
// ----------------------------------------------------------------------------
// vcc_ctrl
// Sequencer: takes a request word, has it evaluated, then drives the change run.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vending_controller_with_change_core_defines.svh"

module vcc_ctrl
  import vcc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  vcc_sts_t sts_i,
  output vcc_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_CHANGE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.latch_in  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.eval_fire = (state_q == S_EVAL) && sts_i.out_free &&
                      (sts_i.outcome != OC_NONE);
    cmd_o.step_fire = (state_q == S_CHANGE) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.outcome == OC_NONE) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          state_d = (sts_i.outcome == OC_SINGLE) ? S_IDLE : S_CHANGE;
        end
      end
      S_CHANGE: begin
        if (sts_i.out_free && sts_i.run_end) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `VCC_ASSERT_NEXT(a_accept_evals, cmd_o.latch_in, state_q == S_EVAL,
                   "accepted word not evaluated")
  `VCC_ASSERT_NOW(a_run_needs_purchase, state_q == S_CHANGE, !in_ready_o,
                  "input open during change run")
  `VCC_ASSERT_NEXT(a_run_closes, cmd_o.step_fire && sts_i.run_end, state_q == S_IDLE,
                   "change run did not close")

endmodule

`default_nettype wire

[sv/vcc_datapath.sv]
// ----------------------------------------------------------------------------
// vcc_datapath
// Price and stock registers, purchase state, change counter, output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vending_controller_with_change_core_defines.svh"

module vcc_datapath
  import vcc_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [PriceW-1:0]   cfg_wdata_i,
  // request word
  input  logic [1:0]          req_i,
  input  logic [SlotW-1:0]    slot_i,
  input  logic [CoinInW-1:0]  coin_i,
  input  logic [StockW-1:0]   stockv_i,
  // result word
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output status_e             out_status_o,
  output logic [CoinOutW-1:0] out_coin_o,
  output logic [PriceW-1:0]   out_left_o,
  output logic                out_last_o,
  // control
  input  vcc_cmd_t            cmd_i,
  output vcc_sts_t            sts_o
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // latched request
  logic [1:0]         req_q;
  logic [SlotW-1:0]   slot_q;
  logic [CoinInW-1:0] coin_q;
  logic [StockW-1:0]  stockv_q;

  // machine state
  logic [MaxSlots-1:0][PriceW-1:0]  price_q;
  logic [NUM_SLOTS-1:0][StockW-1:0] stock_q;
  logic                             paying_q;
  logic [IdxW-1:0]                  chosen_q;
  logic [PriceW-1:0]                amt_q;
  logic [CoinOutW-1:0]              change_q;
  logic [ItemCntW-1:0]              k_q;

  // output register
  logic                out_valid_q;
  status_e             out_st_q;
  logic [CoinOutW-1:0] out_coin_q;
  logic [PriceW-1:0]   out_left_q;
  logic                out_last_q;

  // decode
  logic [SlotW-1:0]    slot_m1;
  logic [IdxW-1:0]     idx;
  logic                slot_ok;
  logic [PriceW-1:0]   price_rd;
  logic [StockW-1:0]   stock_rd;
  logic                coin_good;
  logic                coin_short;
  outcome_e            oc;
  logic                ev_emit;
  status_e             ev_st;
  logic [PriceW-1:0]   ev_left;
  logic                ev_last;
  logic                take_sel;
  logic                take_sub;
  logic                take_stock;
  logic [IdxW-1:0]     dec_idx;
  logic [CoinOutW-1:0] step_coin;
  logic                run_end;
  logic                out_free;

  assign slot_m1    = slot_q - SlotW'(1);
  assign idx        = slot_m1[IdxW-1:0];
  assign slot_ok    = (slot_q != '0) && (slot_q <= SlotW'(NUM_SLOTS));
  assign price_rd   = price_q[slot_m1];
  assign stock_rd   = stock_q[idx];
  assign coin_good  = (coin_q == 8'd1) || (coin_q == 8'd5) ||
                      (coin_q == 8'd10) || (coin_q == 8'd20);
  assign coin_short = (coin_q < amt_q);

  always_comb begin
    oc         = OC_SINGLE;
    ev_emit    = 1'b1;
    ev_st      = ST_WRONG_PHASE;
    ev_left    = '0;
    ev_last    = 1'b1;
    take_sel   = 1'b0;
    take_sub   = 1'b0;
    take_stock = 1'b0;
    unique case (req_q)
      REQ_SELECT: begin
        if (paying_q) begin
          ev_left = amt_q;
        end else if (!slot_ok) begin
          ev_st = ST_BAD_SLOT;
        end else if (stock_rd == '0) begin
          ev_st = ST_EMPTY;
        end else begin
          ev_st    = ST_SELECTED;
          take_sel = 1'b1;
          if (price_rd == '0) begin
            oc      = OC_ZERO_PRICE;
            ev_last = 1'b0;
          end else begin
            ev_left = price_rd;
          end
        end
      end
      REQ_COIN: begin
        if (!paying_q) begin
          ev_st = ST_WRONG_PHASE;
        end else if (!coin_good) begin
          ev_st   = ST_COIN_REJ;
          ev_left = amt_q;
        end else if (coin_short) begin
          ev_st    = ST_COIN_OK;
          ev_left  = amt_q - coin_q;
          take_sub = 1'b1;
        end else begin
          oc      = OC_PAY;
          ev_emit = 1'b0;
        end
      end
      REQ_STOCK: begin
        if (paying_q) begin
          ev_left = amt_q;
        end else if (!slot_ok) begin
          ev_st = ST_BAD_SLOT;
        end else begin
          ev_st      = ST_DONE;
          take_stock = 1'b1;
        end
      end
      default: begin
        oc      = OC_NONE;
        ev_emit = 1'b0;
      end
    endcase
  end

  assign dec_idx   = (oc == OC_ZERO_PRICE) ? idx : chosen_q;
  assign step_coin = change_coin(change_q);
  assign run_end   = (change_q == '0) || (k_q == ItemCap);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o          = '0;
    sts_o.out_free = out_free;
    sts_o.outcome  = oc;
    sts_o.run_end  = run_end;
  end

  // request latch, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      req_q    <= req_i;
      slot_q   <= slot_i;
      coin_q   <= coin_i;
      stockv_q <= stockv_i;
    end
  end

  // price registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      price_q <= PriceRst;
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(MaxSlots))) begin
      price_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // purchase state and stock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stock_q  <= {NUM_SLOTS{StockRst}};
      paying_q <= 1'b0;
      chosen_q <= '0;
      amt_q    <= '0;
      change_q <= '0;
      k_q      <= '0;
    end else if (cmd_i.eval_fire) begin
      if (take_sel) begin
        chosen_q <= idx;
        if (oc != OC_ZERO_PRICE) begin
          paying_q <= 1'b1;
          amt_q    <= price_rd;
        end
      end
      if (take_sub) begin
        amt_q <= amt_q - coin_q;
      end
      if (take_stock) begin
        stock_q[idx] <= stockv_q;
      end
      if ((oc == OC_ZERO_PRICE) || (oc == OC_PAY)) begin
        if (stock_q[dec_idx] != '0) begin
          stock_q[dec_idx] <= stock_q[dec_idx] - StockW'(1);
        end
        // coin is at most 20 here, so the overpayment fits five bits
        change_q <= (oc == OC_PAY) ? CoinOutW'(coin_q - amt_q) : '0;
        k_q      <= (oc == OC_PAY) ? '0 : ItemCntW'(1);
      end
    end else if (cmd_i.step_fire) begin
      if (run_end) begin
        paying_q <= 1'b0;
        amt_q    <= '0;
      end else begin
        change_q <= change_q - step_coin;
        k_q      <= k_q + ItemCntW'(1);
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.eval_fire && ev_emit) || cmd_i.step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_fire && ev_emit) begin
      out_st_q   <= ev_st;
      out_coin_q <= '0;
      out_left_q <= ev_left;
      out_last_q <= ev_last;
    end else if (cmd_i.step_fire) begin
      out_st_q   <= run_end ? ST_DONE : ST_CHANGE;
      out_coin_q <= run_end ? '0 : step_coin;
      out_left_q <= '0;
      out_last_q <= run_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_st_q;
  assign out_coin_o   = out_coin_q;
  assign out_left_o   = out_left_q;
  assign out_last_o   = out_last_q;

  `VCC_ASSERT_NOW(a_paying_owes, paying_q, amt_q != '0,
                  "paying with nothing due")
  `VCC_ASSERT_NOW(a_cnt_cap, 1'b1, k_q <= ItemCap,
                  "change word count overran")
  `VCC_ASSERT_NOW(a_no_overwrite, cmd_i.eval_fire || cmd_i.step_fire,
                  !out_valid_q || out_ready_i, "output word overwritten")
  `VCC_ASSERT_NOW(a_change_word, out_valid_q && (out_st_q == ST_CHANGE),
                  (out_coin_q != '0) && !out_last_q, "malformed change word")

endmodule

`default_nettype wire

[dv/tb_vending_controller_with_change_core.sv]
// ----------------------------------------------------------------------------
// tb_vending_controller_with_change_core
// Self-checking bench for the vending controller.
// ----------------------------------------------------------------------------
// Request words go in on the slave stream and result words are checked as
// they leave the master stream. A ledger object tracks prices, stock, the
// selected slot and the amount still due. For every accepted request it
// queues the words the controller should return. A short directed run covers
// each status code and the zero-price, biggest-change and empty-slot cases.
// Five random phases follow, each with its own price set. Most traffic is
// complete purchases, with bad slots, junk coins, out-of-phase requests and
// the undefined request type mixed in. Both stream sides idle at random. One
// phase runs with no idling and holds the output off for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vending_controller_with_change_core;
  import vcc_pkg::*;

  // price register map
  localparam logic [CfgIdxW-1:0] IdxPriceSlot1 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] IdxUnmapped   = CfgIdxW'(5);

  // request type with no defined meaning, dropped by the controller
  localparam logic [1:0] ReqUndefined = 2'd3;

  localparam int unsigned DrainCycles = 16;    // covers a full change run
  localparam int unsigned HoldCycles  = 150;   // long output hold-off
  localparam int unsigned StallLimit  = 3000;  // cycles with no word moving
  localparam int unsigned PhaseWords  = 42;

  typedef struct packed {
    status_e               status;
    logic [CoinOutW-1:0]   coin_out;
    logic [PriceW-1:0]     amount_left;
    logic                  last;
  } vend_word_t;

  // Tracks the controller's state and the result words it still owes.
  class vend_ledger;
    logic [PriceW-1:0] price [MaxSlots];
    logic [StockW-1:0] stock [MaxSlots];
    bit                paying;
    int unsigned       chosen;
    int unsigned       due;
    vend_word_t        owed_words [$];
    int unsigned       mismatches;
    int unsigned       requests;
    int unsigned       words;
    int unsigned       purchases;
    int unsigned       change_coins;

    function new();
      for (int i = 0; i < MaxSlots; i++) begin
        price[i] = PriceRst[i];
        stock[i] = StockRst;
      end
      paying = 1'b0;
      chosen = 0;
      due    = 0;
    endfunction

    function void set_price(int unsigned idx, logic [PriceW-1:0] value);
      price[idx] = value;
    endfunction

    function int unsigned pending();
      return owed_words.size();
    endfunction

    function void owe(status_e st, int unsigned coin, int unsigned left, bit last);
      vend_word_t w;
      w.status      = st;
      w.coin_out    = CoinOutW'(coin);
      w.amount_left = PriceW'(left);
      w.last        = last;
      owed_words.push_back(w);
    endfunction

    // Purchase completes: stock drops, change goes out largest divisor
    // first, and a done word closes the run.
    function void settle(int unsigned change, int unsigned k);
      int unsigned idx;
      int unsigned coin;
      idx = (chosen - 1) % MaxSlots;
      if (stock[idx] > 0) stock[idx]--;
      purchases++;
      while (change > 0 && k < ItemCap) begin
        if (change % 20 == 0)      coin = 20;
        else if (change % 10 == 0) coin = 10;
        else if (change % 5 == 0)  coin = 5;
        else                       coin = 1;
        change -= coin;
        change_coins++;
        owe(ST_CHANGE, coin, 0, 1'b0);
        k++;
      end
      owe(ST_DONE, 0, 0, 1'b1);
      paying = 1'b0;
      due    = 0;
    endfunction

    function void take_request(logic [1:0] req, logic [SlotW-1:0] slot,
                               logic [CoinInW-1:0] coin, logic [StockW-1:0] stock_val);
      bit slot_ok;
      bit coin_ok;
      slot_ok = (slot >= 1) && (slot <= NumSlotsDef);
      coin_ok = (coin == 1) || (coin == 5) || (coin == 10) || (coin == 20);
      case (req)
        REQ_SELECT: begin
          requests++;
          if (paying) begin
            owe(ST_WRONG_PHASE, 0, due, 1'b1);
          end else if (!slot_ok) begin
            owe(ST_BAD_SLOT, 0, 0, 1'b1);
          end else if (stock[slot - 1] == 0) begin
            owe(ST_EMPTY, 0, 0, 1'b1);
          end else begin
            chosen = slot;
            due    = price[slot - 1];
            if (due == 0) begin
              // free item: selected word, then done straight away
              owe(ST_SELECTED, 0, 0, 1'b0);
              settle(0, 1);
            end else begin
              paying = 1'b1;
              owe(ST_SELECTED, 0, due, 1'b1);
            end
          end
        end
        REQ_COIN: begin
          requests++;
          if (!paying) begin
            owe(ST_WRONG_PHASE, 0, 0, 1'b1);
          end else if (!coin_ok) begin
            owe(ST_COIN_REJ, 0, due, 1'b1);
          end else if (coin < due) begin
            due -= coin;
            owe(ST_COIN_OK, 0, due, 1'b1);
          end else begin
            settle(coin - due, 0);
          end
        end
        REQ_STOCK: begin
          requests++;
          if (paying) begin
            owe(ST_WRONG_PHASE, 0, due, 1'b1);
          end else if (!slot_ok) begin
            owe(ST_BAD_SLOT, 0, 0, 1'b1);
          end else begin
            stock[slot - 1] = stock_val;
            owe(ST_DONE, 0, 0, 1'b1);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void match_word(vend_word_t got);
      vend_word_t exp;
      words++;
      if (owed_words.size() == 0) begin
        $error("unexpected word: status %0d coin_out %0d amount_left %0d last %0d",
               got.status, got.coin_out, got.amount_left, got.last);
        mismatches++;
        return;
      end
      exp = owed_words.pop_front();
      if (got.status != exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        mismatches++;
      end
      if (got.coin_out != exp.coin_out) begin
        $error("coin_out: expected %0d, got %0d", exp.coin_out, got.coin_out);
        mismatches++;
      end
      if (got.amount_left != exp.amount_left) begin
        $error("amount_left: expected %0d, got %0d", exp.amount_left, got.amount_left);
        mismatches++;
      end
      if (got.last != exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [PriceW-1:0]  cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata  = '0;  // slot[2:0], coin[10:3], stock[18:11]
  logic [1:0]         s_axis_tuser  = '0;  // req_type
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;        // coin_out[4:0], amount_left[12:5]
  logic [2:0]         m_axis_tuser;        // status
  logic               m_axis_tlast;

  vend_ledger  ledger = new();
  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;
  bit          rx_hold_req = 1'b0;
  int unsigned price_sets  = 0;
  int unsigned quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  vending_controller_with_change_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // mostly short pauses, now and then a long one
  function automatic int unsigned pick_pause();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [CoinInW-1:0] legal_coin();
    case ($urandom_range(0, 3))
      0:       return CoinInW'(1);
      1:       return CoinInW'(5);
      2:       return CoinInW'(10);
      default: return CoinInW'(20);
    endcase
  endfunction

  function automatic logic [MaxSlots-1:0][PriceW-1:0] rand_prices(int unsigned lo,
                                                                  int unsigned hi);
    logic [MaxSlots-1:0][PriceW-1:0] p;
    for (int i = 0; i < MaxSlots; i++) p[i] = PriceW'($urandom_range(lo, hi));
    return p;
  endfunction

  // Result side: check each accepted word, then choose tready for the next
  // cycle. Only one nonblocking write to tready per edge.
  initial begin
    int unsigned rx_wait;
    vend_word_t  got;
    rx_wait = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.status      = status_e'(m_axis_tuser);
        got.coin_out    = m_axis_tdata[4:0];
        got.amount_left = m_axis_tdata[12:5];
        got.last        = m_axis_tlast;
        ledger.match_word(got);
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_wait     = HoldCycles;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 99) < 35) begin
        rx_wait = pick_pause() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog: nothing moving on either stream for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offers one request word and returns once it is taken. tvalid is left
  // high so back-to-back words need no second write in the same step.
  task automatic send_request(input logic [1:0] req, input logic [SlotW-1:0] slot,
                              input logic [CoinInW-1:0] coin,
                              input logic [StockW-1:0] stock_val);
    int unsigned gap;
    gap = (tx_idle_on && $urandom_range(0, 99) < 40) ? pick_pause() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, stock_val, coin, slot};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.take_request(req, slot, coin, stock_val);
  endtask

  // Stop offering, wait for every owed word, then let an undefined request
  // or the tail of a run clear the controller.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_prices(input logic [MaxSlots-1:0][PriceW-1:0] p,
                                input bit poke_unmapped);
    for (int i = 0; i < MaxSlots; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CfgIdxW'(IdxPriceSlot1 + i);
      cfg_wdata_i <= p[i];
      @(posedge clk_i);
      ledger.set_price(i, p[i]);
    end
    if (poke_unmapped) begin
      // index outside the map, must leave every price alone
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= IdxUnmapped;
      cfg_wdata_i <= PriceW'($urandom_range(0, 255));
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    price_sets++;
  endtask

  // Mostly complete purchases with random content; noise in between. Once
  // the word budget is spent, only legal coins until the purchase closes.
  task automatic run_random_phase(input int unsigned target);
    int unsigned       start;
    int unsigned       r;
    logic [1:0]        req;
    logic [SlotW-1:0]  slot;
    logic [CoinInW-1:0] coin;
    logic [StockW-1:0] stock_val;
    start = ledger.requests;
    while (ledger.requests - start < target || ledger.paying) begin
      slot = SlotW'($urandom_range(1, NumSlotsDef));
      coin = CoinInW'($urandom_range(0, 255));
      r    = $urandom_range(0, 99);
      if (r < 40)      stock_val = StockW'($urandom_range(0, 3));
      else if (r < 80) stock_val = StockW'($urandom_range(4, 10));
      else             stock_val = StockW'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (ledger.requests - start >= target) begin
        req  = REQ_COIN;
        coin = legal_coin();
      end else if (ledger.paying) begin
        if (r < 82) begin
          req  = REQ_COIN;
          coin = legal_coin();
        end else if (r < 88) req = REQ_COIN;
        else if (r < 93)     req = REQ_SELECT;
        else if (r < 97)     req = REQ_STOCK;
        else                 req = ReqUndefined;
      end else begin
        if (r < 55)      req = REQ_SELECT;
        else if (r < 80) req = REQ_STOCK;
        else if (r < 95) req = REQ_COIN;
        else             req = ReqUndefined;
        // out-of-range slot now and then
        if ($urandom_range(0, 99) < 12) slot = SlotW'($urandom_range(0, 2) == 0 ? 0 :
                                                      $urandom_range(6, 7));
      end
      send_request(req, slot, coin, stock_val);
    end
  endtask

  initial begin
    logic [MaxSlots-1:0][PriceW-1:0] prices;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every status code with reset prices
    send_request(REQ_STOCK,    3'd0, 8'd0,   8'd7);    // bad slot
    send_request(REQ_STOCK,    3'd7, 8'd255, 8'd255);  // bad slot
    send_request(REQ_SELECT,   3'd0, 8'd0,   8'd0);    // bad slot
    send_request(REQ_SELECT,   3'd6, 8'd0,   8'd0);    // bad slot
    send_request(REQ_COIN,     3'd1, 8'd20,  8'd0);    // coin while idle
    send_request(ReqUndefined, 3'd5, 8'd255, 8'd255);  // dropped
    send_request(REQ_SELECT,   3'd1, 8'd0,   8'd0);    // due 25
    send_request(REQ_SELECT,   3'd2, 8'd0,   8'd0);    // wrong phase
    send_request(REQ_STOCK,    3'd3, 8'd0,   8'd9);    // wrong phase
    send_request(REQ_COIN,     3'd1, 8'd0,   8'd0);    // rejected
    send_request(REQ_COIN,     3'd1, 8'd255, 8'd0);    // rejected
    send_request(REQ_COIN,     3'd1, 8'd3,   8'd0);    // rejected
    send_request(REQ_COIN,     3'd1, 8'd20,  8'd0);    // 5 left
    send_request(REQ_COIN,     3'd1, 8'd1,   8'd0);    // 4 left
    send_request(REQ_COIN,     3'd1, 8'd5,   8'd0);    // change 1
    send_request(REQ_STOCK,    3'd2, 8'd0,   8'd0);    // slot 2 empty
    send_request(REQ_SELECT,   3'd2, 8'd0,   8'd0);    // empty slot
    send_request(REQ_STOCK,    3'd5, 8'd0,   8'd255);  // full stock
    quiesce();

    // free item, smallest and largest prices
    prices = {PriceW'(37), PriceW'(0), PriceW'(255), PriceW'(200), PriceW'(1)};
    program_prices(prices, 1'b1);
    send_request(REQ_SELECT, 3'd4, 8'd0,  8'd0);  // zero price
    send_request(REQ_SELECT, 3'd1, 8'd0,  8'd0);  // due 1
    send_request(REQ_COIN,   3'd1, 8'd20, 8'd0);  // change 19: longest run
    send_request(REQ_SELECT, 3'd5, 8'd0,  8'd0);  // due 37
    send_request(REQ_COIN,   3'd1, 8'd20, 8'd0);
    send_request(REQ_COIN,   3'd1, 8'd20, 8'd0);  // change 3
    quiesce();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: prices = rand_prices(10, 40);
        1: begin
          prices    = rand_prices(1, 60);
          prices[0] = PriceW'(0);
          prices[4] = PriceW'(255);
        end
        2: prices = rand_prices(1, 25);
        3: prices = rand_prices(0, 255);
        default: prices = rand_prices(1, 60);
      endcase
      program_prices(prices, 1'b0);
      // phase 2 runs flat out apart from one long output hold-off that
      // backs the controller up onto its input
      tx_idle_on = (ph != 2);
      rx_idle_on = (ph != 2);
      if (ph == 2) rx_hold_req = 1'b1;
      run_random_phase(PhaseWords);
      quiesce();
    end

    $display("Covered %0d requests, %0d purchases, %0d change coins, %0d result words.",
             ledger.requests, ledger.purchases, ledger.change_coins, ledger.words);
    $display("Ran %0d price sets with random stream gaps and one long output hold-off.",
             price_sets);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+sv
sv/vcc_pkg.sv
sv/vcc_ctrl.sv
sv/vcc_datapath.sv
sv/vending_controller_with_change_core.sv
dv/tb_vending_controller_with_change_core.sv
